>>> src/tcpq_pkg.sv
// Shared types and constants for the three-class priority queue.
// Used by the stack, ring and top-level modules; depends on nothing.
package tcpq_pkg;

    localparam int ClassDepth = 16;
    localparam int IdxW       = $clog2(ClassDepth);
    localparam int CntW       = $clog2(ClassDepth + 1);

    localparam logic       REQ_INSERT = 1'b0;
    localparam logic       REQ_SERVE  = 1'b1;

    localparam logic [1:0] CLS_LIGHT  = 2'd0;
    localparam logic [1:0] CLS_MEDIUM = 2'd1;
    localparam logic [1:0] CLS_SEVERE = 2'd2;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]  age;
        logic [15:0] tag;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_class_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_class_sts;

endpackage

>>> src/tcpq_stack.sv
// Last-in first-out store for one class of entries.
// Depends on tcpq_pkg for the depth, the entry type and the control structs.
module tcpq_stack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcpq_pkg::t_class_ctl i_ctl,
    input  tcpq_pkg::t_entry     i_data,
    output tcpq_pkg::t_class_sts o_sts,
    output tcpq_pkg::t_entry     o_top
);

    tcpq_pkg::t_entry           r_mem [tcpq_pkg::ClassDepth];
    logic [tcpq_pkg::CntW-1:0]  r_count;
    logic [tcpq_pkg::CntW-1:0]  n_count;
    logic [tcpq_pkg::IdxW-1:0]  w_top_idx;

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == tcpq_pkg::CntW'(tcpq_pkg::ClassDepth));
    assign w_top_idx   = tcpq_pkg::IdxW'(r_count - tcpq_pkg::CntW'(1));
    assign o_top       = r_mem[w_top_idx];

    always_comb begin
        n_count = r_count;
        if (i_ctl.push && !o_sts.full) begin
            n_count = r_count + tcpq_pkg::CntW'(1);
        end else if (i_ctl.pop && !o_sts.empty) begin
            n_count = r_count - tcpq_pkg::CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !o_sts.full) begin
            r_mem[r_count[tcpq_pkg::IdxW-1:0]] <= i_data;
        end
    end

endmodule

>>> src/tcpq_ring.sv
// First-in first-out ring buffer for the light class.
// Depends on tcpq_pkg for the depth, the entry type and the control structs.
module tcpq_ring (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcpq_pkg::t_class_ctl i_ctl,
    input  tcpq_pkg::t_entry     i_data,
    output tcpq_pkg::t_class_sts o_sts,
    output tcpq_pkg::t_entry     o_head
);

    tcpq_pkg::t_entry           r_mem [tcpq_pkg::ClassDepth];
    logic [tcpq_pkg::IdxW-1:0]  r_rd_ptr;
    logic [tcpq_pkg::IdxW-1:0]  r_wr_ptr;
    logic [tcpq_pkg::CntW-1:0]  r_count;
    logic                       w_do_push;
    logic                       w_do_pop;

    function automatic logic [tcpq_pkg::IdxW-1:0] next_slot(
        input logic [tcpq_pkg::IdxW-1:0] p
    );
        if (p == tcpq_pkg::IdxW'(tcpq_pkg::ClassDepth - 1)) begin
            return '0;
        end
        return p + tcpq_pkg::IdxW'(1);
    endfunction

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == tcpq_pkg::CntW'(tcpq_pkg::ClassDepth));
    assign o_head      = r_mem[r_rd_ptr];
    assign w_do_push   = i_ctl.push && !o_sts.full;
    assign w_do_pop    = i_ctl.pop && !i_ctl.push && !o_sts.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else if (w_do_push) begin
            r_wr_ptr <= next_slot(r_wr_ptr);
            r_count  <= r_count + tcpq_pkg::CntW'(1);
        end else if (w_do_pop) begin
            r_rd_ptr <= next_slot(r_rd_ptr);
            r_count  <= r_count - tcpq_pkg::CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/three_class_priority_queue.sv
// Bounded three-class priority queue: input register, request logic, result register.
// Depends on tcpq_pkg, tcpq_stack and tcpq_ring.
//
// Usage: each input beat is one request. An insert (req_type 0) files an entry
// by item_class: severe and medium entries go on stacks (newest served first),
// light entries go into a ring (oldest served first). A serve (req_type 1)
// removes the front entry: severe first, then medium, then light. Every request
// gives exactly one result beat carrying a status: inserted, served, queue
// empty, or class full. Result class, age and tag are zero unless served.
// A request passes through the input register and then the result register.
// Throughput is one request per cycle while the receiver does not stall; each
// request touches only the top or head of one class store. Reset empties all
// three classes and drops any beat in flight.
// When the receiver stalls, the result register holds its beat; the input
// register then holds the next request and o_in_stall rises until it drains.
module three_class_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [1:0]  i_item_class,
    input  logic [7:0]  i_item_age,
    input  logic [15:0] i_item_tag,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_out_class,
    output logic [7:0]  o_out_age,
    output logic [15:0] o_out_tag
);

    logic                 r_in_valid;
    logic                 r_req_type;
    logic [1:0]           r_item_class;
    tcpq_pkg::t_entry     r_item;

    logic                 r_out_valid;
    tcpq_pkg::t_status    r_status;
    logic [1:0]           r_out_class;
    tcpq_pkg::t_entry     r_out_entry;

    tcpq_pkg::t_status    n_status;
    logic [1:0]           n_out_class;
    tcpq_pkg::t_entry     n_out_entry;

    logic                 w_advance;
    logic                 w_accept;
    logic                 w_work;
    tcpq_pkg::t_class_ctl w_sev_ctl;
    tcpq_pkg::t_class_ctl w_med_ctl;
    tcpq_pkg::t_class_ctl w_lgt_ctl;
    tcpq_pkg::t_class_sts w_sev_sts;
    tcpq_pkg::t_class_sts w_med_sts;
    tcpq_pkg::t_class_sts w_lgt_sts;
    tcpq_pkg::t_entry     w_sev_top;
    tcpq_pkg::t_entry     w_med_top;
    tcpq_pkg::t_entry     w_lgt_head;

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_work     = r_in_valid && w_advance;

    tcpq_stack u_severe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sev_ctl),
        .i_data  (r_item),
        .o_sts   (w_sev_sts),
        .o_top   (w_sev_top)
    );

    tcpq_stack u_medium (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_med_ctl),
        .i_data  (r_item),
        .o_sts   (w_med_sts),
        .o_top   (w_med_top)
    );

    tcpq_ring u_light (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_lgt_ctl),
        .i_data  (r_item),
        .o_sts   (w_lgt_sts),
        .o_head  (w_lgt_head)
    );

    always_comb begin
        w_sev_ctl   = '0;
        w_med_ctl   = '0;
        w_lgt_ctl   = '0;
        n_status    = tcpq_pkg::ST_FULL;
        n_out_class = tcpq_pkg::CLS_LIGHT;
        n_out_entry = '0;
        if (r_req_type == tcpq_pkg::REQ_INSERT) begin
            case (r_item_class)
                tcpq_pkg::CLS_SEVERE: begin
                    w_sev_ctl.push = w_work;
                    if (!w_sev_sts.full) begin
                        n_status = tcpq_pkg::ST_INSERTED;
                    end
                end
                tcpq_pkg::CLS_MEDIUM: begin
                    w_med_ctl.push = w_work;
                    if (!w_med_sts.full) begin
                        n_status = tcpq_pkg::ST_INSERTED;
                    end
                end
                tcpq_pkg::CLS_LIGHT: begin
                    w_lgt_ctl.push = w_work;
                    if (!w_lgt_sts.full) begin
                        n_status = tcpq_pkg::ST_INSERTED;
                    end
                end
                default: begin
                    n_status = tcpq_pkg::ST_FULL;
                end
            endcase
        end else if (!w_sev_sts.empty) begin
            w_sev_ctl.pop = w_work;
            n_status      = tcpq_pkg::ST_SERVED;
            n_out_class   = tcpq_pkg::CLS_SEVERE;
            n_out_entry   = w_sev_top;
        end else if (!w_med_sts.empty) begin
            w_med_ctl.pop = w_work;
            n_status      = tcpq_pkg::ST_SERVED;
            n_out_class   = tcpq_pkg::CLS_MEDIUM;
            n_out_entry   = w_med_top;
        end else if (!w_lgt_sts.empty) begin
            w_lgt_ctl.pop = w_work;
            n_status      = tcpq_pkg::ST_SERVED;
            n_out_class   = tcpq_pkg::CLS_LIGHT;
            n_out_entry   = w_lgt_head;
        end else begin
            n_status = tcpq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type   <= i_req_type;
            r_item_class <= i_item_class;
            r_item.age   <= i_item_age;
            r_item.tag   <= i_item_tag;
        end
        if (w_work) begin
            r_status    <= n_status;
            r_out_class <= n_out_class;
            r_out_entry <= n_out_entry;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_class = r_out_class;
    assign o_out_age   = r_out_entry.age;
    assign o_out_tag   = r_out_entry.tag;

endmodule

>>> tb/sv/three_class_priority_queue_tb.sv
// Testbench for three_class_priority_queue: directed and random request streams
// are checked against a predictor of the severe, medium and light stores.
// Depends on tcpq_pkg and the three_class_priority_queue RTL.
module three_class_priority_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CLS_UNUSED   = 2'd3;
    localparam int         CycleLimit   = 400000;
    localparam int         RandomItems  = 1050;
    localparam int         DrainCycles  = 8;

    typedef struct packed {
        tcpq_pkg::t_status status;
        logic [1:0]        cls;
        logic [7:0]        age;
        logic [15:0]       tag;
    } t_outcome;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_req_type   = 1'b0;
    logic [1:0]  i_item_class = 2'd0;
    logic [7:0]  i_item_age   = 8'd0;
    logic [15:0] i_item_tag   = 16'd0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [1:0]  o_out_class;
    logic [7:0]  o_out_age;
    logic [15:0] o_out_tag;

    tcpq_pkg::t_entry severe_pile [tcpq_pkg::ClassDepth];
    tcpq_pkg::t_entry medium_pile [tcpq_pkg::ClassDepth];
    tcpq_pkg::t_entry light_fifo  [tcpq_pkg::ClassDepth];
    int       severe_fill = 0;
    int       medium_fill = 0;
    int       light_fill  = 0;
    int       light_head  = 0;
    int       light_tail  = 0;
    t_outcome pending_outcomes [$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       in_idle_on     = 1'b1;
    bit       out_idle_on    = 1'b1;

    three_class_priority_queue i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_item_class (i_item_class),
        .i_item_age   (i_item_age),
        .i_item_tag   (i_item_tag),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_out_class  (o_out_class),
        .o_out_age    (o_out_age),
        .o_out_tag    (o_out_tag)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_outcome serve_or_file(logic req, logic [1:0] cls,
                                               logic [7:0] age, logic [15:0] tag);
        t_outcome         res;
        tcpq_pkg::t_entry ent;
        res = '{status: tcpq_pkg::ST_INSERTED, cls: 2'd0, age: 8'd0, tag: 16'd0};
        ent = '{age: age, tag: tag};
        if (req == tcpq_pkg::REQ_INSERT) begin
            if (cls == tcpq_pkg::CLS_SEVERE && severe_fill < tcpq_pkg::ClassDepth) begin
                severe_pile[severe_fill] = ent;
                severe_fill++;
            end else if (cls == tcpq_pkg::CLS_MEDIUM &&
                         medium_fill < tcpq_pkg::ClassDepth) begin
                medium_pile[medium_fill] = ent;
                medium_fill++;
            end else if (cls == tcpq_pkg::CLS_LIGHT && light_fill < tcpq_pkg::ClassDepth) begin
                light_fifo[light_tail] = ent;
                light_tail = (light_tail + 1) % tcpq_pkg::ClassDepth;
                light_fill++;
            end else begin
                res.status = tcpq_pkg::ST_FULL;
            end
        end else if (severe_fill > 0) begin
            severe_fill--;
            ent = severe_pile[severe_fill];
            res = '{status: tcpq_pkg::ST_SERVED, cls: tcpq_pkg::CLS_SEVERE,
                    age: ent.age, tag: ent.tag};
        end else if (medium_fill > 0) begin
            medium_fill--;
            ent = medium_pile[medium_fill];
            res = '{status: tcpq_pkg::ST_SERVED, cls: tcpq_pkg::CLS_MEDIUM,
                    age: ent.age, tag: ent.tag};
        end else if (light_fill > 0) begin
            ent = light_fifo[light_head];
            light_head = (light_head + 1) % tcpq_pkg::ClassDepth;
            light_fill--;
            res = '{status: tcpq_pkg::ST_SERVED, cls: tcpq_pkg::CLS_LIGHT,
                    age: ent.age, tag: ent.tag};
        end else begin
            res.status = tcpq_pkg::ST_EMPTY;
        end
        return res;
    endfunction

    function automatic void compare_field(string field, logic [15:0] want,
                                          logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result beat with no expectation, expected none, actual %0h",
                             $time, {o_status, o_out_class, o_out_age, o_out_tag});
                    mismatch_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    compare_field("status", 16'(want.status), 16'(o_status));
                    compare_field("class", 16'(want.cls), 16'(o_out_class));
                    compare_field("age", 16'(want.age), 16'(o_out_age));
                    compare_field("tag", want.tag, o_out_tag);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                pending_outcomes.push_back(serve_or_file(i_req_type, i_item_class,
                                                         i_item_age, i_item_tag));
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= out_idle_on && ($urandom_range(99) < 22);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_beat(logic req, logic [1:0] cls, logic [7:0] age, logic [15:0] tag);
        while (in_idle_on && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_item_class <= cls;
        i_item_age   <= age;
        i_item_tag   <= tag;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic test_serve_when_empty();
        send_beat(tcpq_pkg::REQ_SERVE, CLS_UNUSED, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_severe_newest_first();
        send_beat(tcpq_pkg::REQ_INSERT, tcpq_pkg::CLS_SEVERE, 8'h00, 16'h0000);
        send_beat(tcpq_pkg::REQ_INSERT, tcpq_pkg::CLS_SEVERE, 8'hFF, 16'hFFFF);
        send_beat(tcpq_pkg::REQ_SERVE, tcpq_pkg::CLS_LIGHT, 8'h00, 16'h0000);
        send_beat(tcpq_pkg::REQ_SERVE, tcpq_pkg::CLS_LIGHT, 8'h00, 16'h0000);
    endtask

    task automatic test_medium_after_severe();
        send_beat(tcpq_pkg::REQ_INSERT, tcpq_pkg::CLS_MEDIUM, 8'h5A, 16'hA5A5);
        send_beat(tcpq_pkg::REQ_INSERT, tcpq_pkg::CLS_MEDIUM, 8'h01, 16'h8000);
        send_beat(tcpq_pkg::REQ_INSERT, tcpq_pkg::CLS_SEVERE, 8'h80, 16'h0001);
        repeat (3) send_beat(tcpq_pkg::REQ_SERVE, tcpq_pkg::CLS_MEDIUM, 8'h3C, 16'h1234);
    endtask

    task automatic test_light_oldest_first();
        send_beat(tcpq_pkg::REQ_INSERT, tcpq_pkg::CLS_LIGHT, 8'h11, 16'h1111);
        send_beat(tcpq_pkg::REQ_INSERT, tcpq_pkg::CLS_MEDIUM, 8'h22, 16'h2222);
        send_beat(tcpq_pkg::REQ_INSERT, tcpq_pkg::CLS_LIGHT, 8'h33, 16'h3333);
        repeat (3) send_beat(tcpq_pkg::REQ_SERVE, tcpq_pkg::CLS_SEVERE, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_unused_class_code();
        send_beat(tcpq_pkg::REQ_INSERT, CLS_UNUSED, 8'hFF, 16'hFFFF);
        send_beat(tcpq_pkg::REQ_SERVE, tcpq_pkg::CLS_LIGHT, 8'h00, 16'h0000);
    endtask

    // Bursts lean toward inserts or serves and favor one class, so each
    // class can fill up and the whole queue can run dry again.
    task automatic test_random_traffic();
        int         sent;
        int         burst_len;
        int         insert_pct;
        logic [1:0] favored;
        logic [1:0] cls;
        sent = 0;
        while (sent < RandomItems) begin
            in_idle_on  = !(sent >= 300 && sent < 550);
            out_idle_on = in_idle_on;
            burst_len   = $urandom_range(20, 60);
            case ($urandom_range(2))
                0: insert_pct = 85;
                1: insert_pct = 50;
                default: insert_pct = 15;
            endcase
            favored = 2'($urandom_range(2));
            repeat (burst_len) begin
                if ($urandom_range(99) < 4) begin
                    cls = CLS_UNUSED;
                end else if ($urandom_range(99) < 70) begin
                    cls = favored;
                end else begin
                    cls = 2'($urandom_range(2));
                end
                send_beat(($urandom_range(99) < insert_pct) ? tcpq_pkg::REQ_INSERT
                                                            : tcpq_pkg::REQ_SERVE,
                          cls, 8'($urandom), 16'($urandom));
                sent++;
            end
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_serve_when_empty();
        test_severe_newest_first();
        test_medium_after_severe();
        test_light_oldest_first();
        test_unused_class_code();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
